[design/bmf_pkg.sv]
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants, types and helper functions for the 5x5 box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int Radius     = 2;
  localparam int Win        = 2 * Radius + 1;
  localparam int StepW      = $clog2(Win);

  localparam int DimW       = 11;
  localparam int PosW       = 10;
  localparam int CoordW     = PosW + 2;
  localparam int IdxW       = 20;
  localparam int AddrW      = 13;
  localparam int RingDepth  = 1 << AddrW;
  localparam int PixW       = 8;
  localparam int ChanN      = 3;
  localparam int ChanW      = 2;
  localparam int SumW       = 13;
  localparam int CntW       = 5;
  localparam int RecipW     = 19;
  localparam int RecipShift = 18;
  localparam int ProdW      = 32;
  localparam int QDepth     = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            last;
  } job_t;

  typedef struct packed {
    logic                    en;
    logic [AddrW-1:0]        addr;
    logic [ChanN*PixW-1:0]   data;
  } mem_wr_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ceil(2^18 / n), exact floor division for sums up to 25*255
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] n);
    logic [RecipW-1:0] r;
    unique case (n)
      5'd2:    r = 19'd131072;
      5'd3:    r = 19'd87382;
      5'd4:    r = 19'd65536;
      5'd5:    r = 19'd52429;
      5'd6:    r = 19'd43691;
      5'd7:    r = 19'd37450;
      5'd8:    r = 19'd32768;
      5'd9:    r = 19'd29128;
      5'd10:   r = 19'd26215;
      5'd11:   r = 19'd23832;
      5'd12:   r = 19'd21846;
      5'd13:   r = 19'd20165;
      5'd14:   r = 19'd18725;
      5'd15:   r = 19'd17477;
      5'd16:   r = 19'd16384;
      5'd17:   r = 19'd15421;
      5'd18:   r = 19'd14564;
      5'd19:   r = 19'd13798;
      5'd20:   r = 19'd13108;
      5'd21:   r = 19'd12484;
      5'd22:   r = 19'd11916;
      5'd23:   r = 19'd11398;
      5'd24:   r = 19'd10923;
      5'd25:   r = 19'd10486;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

[design/box_mean_filter_5x5.sv]
// ----------------------------------------------------------------------------
// box_mean_filter_5x5
// Streaming 5x5 box mean filter over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// For each result the engine takes the job from the queue, reads the window
// taps one per cycle through the single read port of the line store, runs
// the shared reciprocal multiply and then hands the result off.
// Beats that give no result are taken one per cycle while the two-entry job
// queue has room; the front end runs up to two jobs ahead of the engine.
// Results lag the input by two rows and two pixels; after the last pixel of
// a frame, send drain beats until the beat flagged frame_end appears. A
// register write restarts the frame and is only allowed while idle.
// ----------------------------------------------------------------------------
module box_mean_filter_5x5 import bmf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [DimW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [PixW-1:0] red_in_i,
  input  logic [PixW-1:0] green_in_i,
  input  logic [PixW-1:0] blue_in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PixW-1:0] red_out_o,
  output logic [PixW-1:0] green_out_o,
  output logic [PixW-1:0] blue_out_o,
  output logic            frame_end_o
);

  logic [DimW-1:0] width_q, height_q, width, height;
  logic            q_full, push, job_valid, pop;
  job_t            job_in, job_out;
  mem_wr_t         wr;

  assign width  = clamp_dim(width_q, DimW'(MaxWidth));
  assign height = clamp_dim(height_q, DimW'(MaxHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(MaxWidth);
      height_q <= DimW'(MaxHeight);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default:    width_q  <= width_q;
      endcase
    end
  end

  bmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .width_i     (width),
    .height_i    (height),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job_in),
    .wr_o        (wr)
  );

  bmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  bmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width),
    .height_i    (height),
    .wr_i        (wr),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

endmodule

[design/bmf_front.sv]
// ----------------------------------------------------------------------------
// bmf_front
// Accepts input beats, writes pixels into the line store, tracks frame
// positions and issues one window job per result.
// ----------------------------------------------------------------------------
module bmf_front import bmf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [PixW-1:0] red_in_i,
  input  logic [PixW-1:0] green_in_i,
  input  logic [PixW-1:0] blue_in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output job_t            job_o,
  output mem_wr_t         wr_o
);

  logic [PosW-1:0]   in_col_q, in_col_d, in_row_q, in_row_d;
  logic [PosW-1:0]   out_col_q, out_col_d, out_row_q, out_row_d;
  logic [IdxW-1:0]   in_idx_q, in_idx_d, out_idx_q, out_idx_d;
  logic [AddrW-1:0]  base_q, base_d;
  logic              done_q, done_d;
  logic              accept, pixel, done_now, done_after, pix_emit, emit, last;
  logic [2*DimW-1:0] total;
  logic [IdxW:0]     in_next, out_next, lead_tgt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign pixel      = accept && (operation_i == OP_PIXEL) && !done_q;
  assign total      = (2*DimW)'(width_i) * (2*DimW)'(height_i);
  assign in_next    = (IdxW+1)'(in_idx_q) + (IdxW+1)'(1);
  assign out_next   = (IdxW+1)'(out_idx_q) + (IdxW+1)'(1);
  assign lead_tgt   = (IdxW+1)'(out_idx_q) + (IdxW+1)'(width_i) * (IdxW+1)'(Radius)
                    + (IdxW+1)'(Radius);
  assign done_now   = pixel && ((2*DimW)'(in_next) >= total);
  assign done_after = done_q || done_now;
  assign pix_emit   = pixel && ((IdxW+1)'(in_idx_q) >= lead_tgt);
  assign emit       = accept && (pix_emit || done_after);
  assign last       = (2*DimW)'(out_next) >= total;

  // each frame starts at a fresh ring offset so queued jobs of the previous
  // frame still see their pixels
  assign push_o    = emit;
  assign job_o.idx  = out_idx_q + IdxW'(base_q);
  assign job_o.row  = out_row_q;
  assign job_o.col  = out_col_q;
  assign job_o.last = last;

  assign wr_o.en   = pixel;
  assign wr_o.addr = in_idx_q[AddrW-1:0] + base_q;
  assign wr_o.data = {red_in_i, green_in_i, blue_in_i};

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_idx_d  = in_idx_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    out_idx_d = out_idx_q;
    done_d    = done_q;
    base_d    = base_q;
    if (emit && last) begin
      base_d = base_q + out_next[AddrW-1:0];
    end
    priority if (restart_i || (emit && last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      in_idx_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      out_idx_d = '0;
      done_d    = 1'b0;
    end else begin
      if (pixel) begin
        in_idx_d = in_next[IdxW-1:0];
        done_d   = done_after;
        if ((DimW)'(in_col_q) + DimW'(1) >= width_i) begin
          in_col_d = '0;
          in_row_d = in_row_q + PosW'(1);
        end else begin
          in_col_d = in_col_q + PosW'(1);
        end
      end
      if (emit) begin
        out_idx_d = out_next[IdxW-1:0];
        if ((DimW)'(out_col_q) + DimW'(1) >= width_i) begin
          out_col_d = '0;
          out_row_d = out_row_q + PosW'(1);
        end else begin
          out_col_d = out_col_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_idx_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_idx_q <= '0;
      base_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_idx_q  <= in_idx_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      out_idx_q <= out_idx_d;
      base_q    <= base_d;
      done_q    <= done_d;
    end
  end

endmodule

[design/bmf_queue.sv]
// ----------------------------------------------------------------------------
// bmf_queue
// Short job queue between the front end and the window engine.
// ----------------------------------------------------------------------------
module bmf_queue import bmf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  job_t             ent_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(do_push) - QCntW'(do_pop);
    end
  end

endmodule

[design/bmf_back.sv]
// ----------------------------------------------------------------------------
// bmf_back
// Window engine: holds the line store, walks the 5x5 window one tap per
// cycle, divides the channel sums by the tap count and drives the output.
// ----------------------------------------------------------------------------
module bmf_back import bmf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  mem_wr_t         wr_i,
  input  logic            job_valid_i,
  input  job_t            job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PixW-1:0] red_out_o,
  output logic [PixW-1:0] green_out_o,
  output logic [PixW-1:0] blue_out_o,
  output logic            frame_end_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [ChanN*PixW-1:0] ring_q [RingDepth];
  logic [ChanN*PixW-1:0] rdata_q;

  logic [1:0]               state_q;
  logic [AddrW-1:0]         addr_q;
  logic signed [CoordW-1:0] x_q, y_q, x0_q, x_start, y_start, w_s, h_s;
  logic [StepW-1:0]         dx_q, dy_q;
  logic                     tap_q, in_frame;
  logic [SumW-1:0]          sum_q [ChanN];
  logic [CntW-1:0]          cnt_q;
  logic [2:0]               phase_q;
  logic [RecipW-1:0]        recip_q;
  logic [ProdW-1:0]         prod_q, prod_d;
  logic [ChanW-1:0]         mul_sel, st_sel;
  logic [PixW-1:0]          mean_q [ChanN];
  logic [PixW-1:0]          out_q [ChanN];
  logic                     last_q, out_last_q, out_valid_q, out_free;

  assign w_s      = $signed(CoordW'(width_i));
  assign h_s      = $signed(CoordW'(height_i));
  assign x_start  = $signed(CoordW'(job_i.col) - CoordW'(Radius));
  assign y_start  = $signed(CoordW'(job_i.row) - CoordW'(Radius));
  assign in_frame = (x_q >= 0) && (y_q >= 0) && (x_q < w_s) && (y_q < h_s);
  assign pop_o    = (state_q == ST_IDLE) && job_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign mul_sel  = ChanW'(phase_q - 3'd2);
  assign st_sel   = ChanW'(phase_q - 3'd3);
  assign prod_d   = ProdW'(sum_q[mul_sel]) * ProdW'(recip_q);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ring_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= ring_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q <= job_i.idx[AddrW-1:0] - AddrW'(width_i) * AddrW'(Radius) - AddrW'(Radius);
      x_q    <= x_start;
      x0_q   <= x_start;
      y_q    <= y_start;
      last_q <= job_i.last;
    end else if (state_q == ST_SCAN) begin
      if (dx_q == StepW'(Win - 1)) begin
        addr_q <= addr_q + AddrW'(width_i) - AddrW'(Win - 1);
        x_q    <= x0_q;
        y_q    <= y_q + CoordW'(1);
      end else begin
        addr_q <= addr_q + AddrW'(1);
        x_q    <= x_q + CoordW'(1);
      end
    end
    if (pop_o) begin
      for (int i = 0; i < ChanN; i++) begin
        sum_q[i] <= '0;
      end
    end else if (tap_q) begin
      sum_q[0] <= sum_q[0] + SumW'(rdata_q[3*PixW-1:2*PixW]);
      sum_q[1] <= sum_q[1] + SumW'(rdata_q[2*PixW-1:PixW]);
      sum_q[2] <= sum_q[2] + SumW'(rdata_q[PixW-1:0]);
    end
    if (state_q == ST_DIV) begin
      if (phase_q == 3'd1) begin
        recip_q <= recip(cnt_q);
      end
      if (phase_q >= 3'd2 && phase_q <= 3'd4) begin
        prod_q <= prod_d;
      end
      if (phase_q >= 3'd3) begin
        mean_q[st_sel] <= prod_q[RecipShift+PixW-1:RecipShift];
      end
    end
    if (state_q == ST_HOLD && out_free) begin
      out_q      <= mean_q;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dx_q        <= '0;
      dy_q        <= '0;
      tap_q       <= 1'b0;
      cnt_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tap_q <= (state_q == ST_SCAN) && in_frame;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (tap_q) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (state_q == ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          dx_q <= '0;
          dy_q <= '0;
          if (job_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (dx_q == StepW'(Win - 1)) begin
            dx_q <= '0;
            dy_q <= dy_q + StepW'(1);
            if (dy_q == StepW'(Win - 1)) begin
              state_q <= ST_DIV;
              phase_q <= '0;
            end
          end else begin
            dx_q <= dx_q + StepW'(1);
          end
        end
        ST_DIV: begin
          phase_q <= phase_q + 3'd1;
          if (phase_q == 3'd5) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];
  assign frame_end_o = out_last_q;

endmodule

[design/bmf_checker.sv]
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks for the box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker import bmf_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [PixW-1:0] red_out_o,
  input logic [PixW-1:0] green_out_o,
  input logic [PixW-1:0] blue_out_o,
  input logic            frame_end_o
);

  a_reset_no_out: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output beat during reset");

  a_reset_no_stall: assert property (@(posedge clk_i) !rst_ni |-> !in_stall_o)
    else $error("input stalled during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_out_o) && $stable(green_out_o)
      && $stable(blue_out_o) && $stable(frame_end_o))
    else $error("output payload changed while stalled");

endmodule

bind box_mean_filter_5x5 bmf_checker u_bmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o),
  .frame_end_o (frame_end_o)
);

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for box_mean_filter_5x5: frames of random RGB pixels are
// streamed in under random idling on both channels and each output beat is
// compared with a local window-mean predictor, including border divisors,
// drain beats, frame_end, register clamping and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import bmf_pkg::*;

  localparam int RingSize  = 2 * Radius * MaxWidth + 2 * Radius + 1;
  localparam int WdogLimit = 5000;
  localparam int SettleCyc = 80;

  typedef struct {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            frame_end;
  } mean_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_WIDTH;
  logic [DimW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_PIXEL;
  logic [PixW-1:0] red_in = '0, green_in = '0, blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PixW-1:0] red_out, green_out, blue_out;
  logic frame_end;

  box_mean_filter_5x5 dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .operation_i(operation),
    .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .red_out_o(red_out), .green_out_o(green_out), .blue_out_o(blue_out),
    .frame_end_o(frame_end)
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned width_reg = 1024, height_reg = 1024;
  logic [23:0] pix_ring [RingSize];
  int unsigned in_col, in_row, out_col, out_row;
  bit in_done, frame_done;
  mean_beat_t mean_q[$];

  bit quiet = 1'b0;
  int hold_seq = 0;
  int errors = 0, matched = 0, frames = 0, beats_in = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic restart_prediction();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 0;
  endtask

  task automatic predict_mean(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, total, out_idx, idx, sr, sg, sb, cnt;
    int y, x;
    bit emit;
    logic [23:0] p;
    mean_beat_t e;
    w = clamp_size(width_reg, MaxWidth);
    h = clamp_size(height_reg, MaxHeight);
    total = w * h;
    out_idx = out_row * w + out_col;
    emit = 0;
    if (op == OP_PIXEL && !in_done) begin
      idx = in_row * w + in_col;
      pix_ring[idx % RingSize] = {r, g, b};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (idx + 1 >= total) in_done = 1;
      if (idx >= out_idx + Radius * w + Radius) emit = 1;
    end
    if (in_done) emit = 1;
    if (emit) begin
      sr = 0; sg = 0; sb = 0; cnt = 0;
      for (int dy = -Radius; dy <= Radius; dy++) begin
        y = int'(out_row) + dy;
        if (y < 0 || y >= int'(h)) continue;
        for (int dx = -Radius; dx <= Radius; dx++) begin
          x = int'(out_col) + dx;
          if (x < 0 || x >= int'(w)) continue;
          p = pix_ring[(y * w + x) % RingSize];
          sr += p[23:16]; sg += p[15:8]; sb += p[7:0]; cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      e.red = 8'(sr / cnt); e.green = 8'(sg / cnt); e.blue = 8'(sb / cnt);
      e.frame_end = (out_idx + 1 >= total);
      mean_q.push_back(e);
      if (e.frame_end) begin
        restart_prediction();
        frame_done = 1;
        frames++;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    end
  endtask

  task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    red_in <= r; green_in <= g; blue_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_in++;
    predict_mean(op, r, g, b);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [DimW-1:0] value);
    wait_idle();
    cfg_we <= 1'b1; cfg_index <= index; cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_WIDTH) width_reg = value;
    else height_reg = value;
    restart_prediction();
  endtask

  // one frame; noise adds ignored drains mid-frame and pixels after the end
  task automatic run_frame(int mode, bit noise);
    int unsigned n;
    logic [7:0] r, g, b;
    n = clamp_size(width_reg, MaxWidth) * clamp_size(height_reg, MaxHeight);
    frame_done = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 15) == 0)
        send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      case (mode)
        0: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
        1: begin r = 8'hff; g = 8'hff; b = 8'hff; end
        2: begin r = '0; g = '0; b = '0; end
        default: begin
          r = i[0] ? 8'hff : 8'h00; g = ~r; b = i[1] ? 8'hff : 8'h00;
        end
      endcase
      send_beat(OP_PIXEL, r, g, b);
    end
    while (!frame_done) begin
      if (noise && $urandom_range(0, 3) == 0)
        send_beat(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // start of a frame only; the next register write abandons it
  task automatic run_partial(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_beat(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(CFG_WIDTH, DimW'(w));
    write_reg(CFG_HEIGHT, DimW'(h));
  endtask

  task automatic test_directed();
    set_size(5, 4);
    send_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    run_frame(1, 0);
    set_size(1, 1);
    run_frame(2, 0);
    set_size(0, 3);
    run_frame(3, 0);
  endtask

  task automatic test_extremes();
    set_size(2047, 0);
    run_partial(40);
    set_size(1, 2047);
    run_partial(60);
    set_size(1024, 1024);
    run_partial(40);
  endtask

  task automatic test_backpressure();
    set_size(9, 6);
    hold_seq++;
    run_frame(0, 0);
    wait_idle();
    run_frame(0, 1);
  endtask

  task automatic test_random();
    int start;
    start = beats_in;
    while (beats_in - start < 200) begin
      if ($urandom_range(0, 9) == 0) set_size($urandom_range(20, 40), $urandom_range(1, 6));
      else set_size($urandom_range(1, 12), $urandom_range(1, 10));
      repeat ($urandom_range(1, 2)) run_frame(0, $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic test_quiet();
    wait_idle();
    quiet = 1'b1;
    set_size(7, 5);
    run_frame(0, 0);
    run_frame(3, 0);
  endtask

  // receiver stall: short random bursts, plus a long hold on request
  initial begin
    int seen, burst;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    mean_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %h %h %h end=%b",
                                   red_out, green_out, blue_out, frame_end);
      end else begin
        e = mean_q.pop_front();
        if (e.red !== red_out || e.green !== green_out || e.blue !== blue_out ||
            e.frame_end !== frame_end) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %h %h end=%b, got %h %h %h end=%b",
                     e.red, e.green, e.blue, e.frame_end,
                     red_out, green_out, blue_out, frame_end);
        end else begin
          matched++;
        end
      end
    end
  end

  initial begin
    int idle_cyc;
    idle_cyc = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WdogLimit) begin
        $display("watchdog: no beat for %0d cycles", WdogLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    restart_prediction();
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_backpressure();
    test_random();
    test_quiet();
    wait_idle();
    $display("%0d input beats over %0d frames, %0d output beats checked",
             beats_in, frames, matched);
    if (errors == 0 && mean_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", errors, mean_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
